>>> hw/rtl/gbaf_pkg.sv
package gbaf_pkg;

	// Field widths
	localparam int CMD_W   = 3;
	localparam int BANK_W  = 11;
	localparam int AF_W    = 12;
	localparam int LEVEL_W = 6;

	// Shared pin layout: shared pin s is bank pin SHARED_BASE + s
	localparam int SHARED_MAX  = 6;
	localparam int SHARED_BASE = 5;
	localparam int POWER_BIT   = 4;
	localparam int INPUT_ONLY  = 4;

	typedef logic [1:0] mode_t;

	// Commands
	localparam logic [CMD_W-1:0] CMD_WR_VALUE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_DIR   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_AF    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HOST_RST = 3'd4;

	// Alternate-function codes
	localparam logic [1:0] AF_GPIO = 2'd0;
	localparam logic [1:0] AF_UART = 2'd1;

	// Pin modes
	localparam mode_t MODE_INPUT  = 2'd0;
	localparam mode_t MODE_OUTPUT = 2'd1;
	localparam mode_t MODE_UART   = 2'd2;

	// Register reset values and masks
	localparam logic [BANK_W-1:0] DIR_RESET  = 11'h010;
	localparam logic [BANK_W-1:0] POWER_MASK = 11'h010;

endpackage

>>> hw/rtl/gpio_bank_with_alt_function.sv
// A command passes through the input register, then the result register, and its result
// waits in the result register while the output stalls.
// Throughput: one command per cycle while the output does not stall; each command's update is single-pass bit logic.
// Reset (arst_n low, asynchronous): value, alt-function, pending and drive state clear,
// direction returns to the power-output bit only, all shared pins go to input mode,
// the power-enable state clears and both pipeline stages empty.
module gpio_bank_with_alt_function #(
	parameter int GROUP_COUNT    = 2,
	parameter int PINS_PER_GROUP = 3
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [gbaf_pkg::CMD_W-1:0]              command,
	input  logic [gbaf_pkg::AF_W-1:0]               write_data,
	input  logic                                    voltage_ok,
	input  logic [gbaf_pkg::LEVEL_W-1:0]            pin_levels,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [gbaf_pkg::BANK_W-1:0]             ctrl_readback,
	output logic [gbaf_pkg::BANK_W-1:0]             dir_readback,
	output logic [gbaf_pkg::AF_W-1:0]               af_readback,
	output logic                                    power_out_enable,
	output logic [2*gbaf_pkg::SHARED_MAX-1:0]       pin_modes,
	output logic [gbaf_pkg::SHARED_MAX-1:0]         pin_drive
);
	import gbaf_pkg::*;

	localparam int SHARED_N = (GROUP_COUNT * PINS_PER_GROUP > SHARED_MAX) ?
		SHARED_MAX : GROUP_COUNT * PINS_PER_GROUP;

	// Input stage
	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [AF_W-1:0]      data_s1;
	logic                 vok_s1;
	logic [LEVEL_W-1:0]   lev_s1;

	// Result stage
	logic                 valid_s2;
	logic [BANK_W-1:0]    ctrl_s2;
	logic [BANK_W-1:0]    dir_s2;
	logic [AF_W-1:0]      af_s2;
	logic                 power_s2;
	logic [SHARED_MAX-1:0][1:0] mode_s2;
	logic [SHARED_MAX-1:0]      drive_s2;

	// Bank state
	logic [BANK_W-1:0]    value_q;
	logic [BANK_W-1:0]    dir_q;
	logic [AF_W-1:0]      af_q;
	logic [BANK_W-1:0]    pmask_q;
	logic [BANK_W-1:0]    pval_q;
	logic [SHARED_MAX-1:0][1:0] mode_q;
	logic [SHARED_MAX-1:0]      drive_q;
	logic                 power_q;

	// Next state
	logic [BANK_W-1:0]    value_n;
	logic [BANK_W-1:0]    dir_n;
	logic [AF_W-1:0]      af_n;
	logic [BANK_W-1:0]    pmask_n;
	logic [BANK_W-1:0]    pval_n;
	logic [SHARED_MAX-1:0][1:0] mode_n;
	logic [SHARED_MAX-1:0]      drive_n;
	logic                 power_n;
	logic [BANK_W-1:0]    new_dir;

	logic adv;
	logic in_xfer;
	logic proc;

	// Handshake
	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign in_xfer  = in_valid && in_ready;
	assign proc     = valid_s1 && adv;

	// Command decode and per-pin update
	always_comb begin
		value_n = value_q;
		dir_n   = dir_q;
		af_n    = af_q;
		pmask_n = pmask_q;
		pval_n  = pval_q;
		mode_n  = mode_q;
		drive_n = drive_q;
		power_n = power_q;
		new_dir = {data_s1[BANK_W-1:INPUT_ONLY+1], 1'b1, {INPUT_ONLY{1'b0}}};
		unique case (cmd_s1)
			CMD_WR_VALUE: begin
				value_n = data_s1[BANK_W-1:0];
				pval_n  = data_s1[BANK_W-1:0];
				pmask_n = data_s1[BANK_W-1:0] ^ value_q;
				for (int s = 0; s < SHARED_MAX; s++) begin
					if (s < SHARED_N && pmask_n[SHARED_BASE+s])
						drive_n[s] = value_n[SHARED_BASE+s];
				end
			end
			CMD_WR_DIR: begin
				dir_n = new_dir;
				for (int s = 0; s < SHARED_MAX; s++) begin
					if (s < SHARED_N && new_dir[SHARED_BASE+s] != dir_q[SHARED_BASE+s]) begin
						if (af_q[2*s +: 2] == AF_GPIO) begin
							if (new_dir[SHARED_BASE+s]) begin
								// turning to output: take a pending value if any
								if (pmask_q[SHARED_BASE+s]) begin
									drive_n[s]              = pval_q[SHARED_BASE+s];
									pmask_n[SHARED_BASE+s]  = 1'b0;
									value_n[SHARED_BASE+s]  = pval_q[SHARED_BASE+s];
								end else begin
									drive_n[s] = value_q[SHARED_BASE+s];
								end
								mode_n[s] = MODE_OUTPUT;
							end else begin
								mode_n[s] = MODE_INPUT;
							end
						end else begin
							value_n[SHARED_BASE+s] = 1'b0;
						end
					end
				end
			end
			CMD_WR_AF: begin
				af_n = data_s1;
				for (int s = 0; s < SHARED_MAX; s++) begin
					if (s < SHARED_N) begin
						if (data_s1[2*s +: 2] == AF_GPIO)
							mode_n[s] = dir_q[SHARED_BASE+s] ? MODE_OUTPUT : MODE_INPUT;
						else if (data_s1[2*s +: 2] == AF_UART)
							mode_n[s] = MODE_UART;
					end
				end
			end
			CMD_TICK: begin
				power_n = vok_s1 && value_q[POWER_BIT];
				value_n[INPUT_ONLY-1:0] = '0;
				for (int s = 0; s < SHARED_MAX; s++) begin
					if (s < SHARED_N && mode_q[s] == MODE_INPUT)
						value_n[SHARED_BASE+s] = lev_s1[s];
				end
			end
			CMD_HOST_RST: begin
				value_n = value_q & POWER_MASK;
				af_n    = '0;
				dir_n   = DIR_RESET;
				for (int s = 0; s < SHARED_MAX; s++) begin
					if (s < SHARED_N)
						mode_n[s] = MODE_INPUT;
				end
			end
			default: begin
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= command;
			data_s1 <= write_data;
			vok_s1  <= voltage_ok;
			lev_s1  <= pin_levels;
		end
	end

	// Bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			dir_q   <= DIR_RESET;
			af_q    <= '0;
			pmask_q <= '0;
			pval_q  <= '0;
			mode_q  <= '0;
			drive_q <= '0;
			power_q <= 1'b0;
		end else if (proc) begin
			value_q <= value_n;
			dir_q   <= dir_n;
			af_q    <= af_n;
			pmask_q <= pmask_n;
			pval_q  <= pval_n;
			mode_q  <= mode_n;
			drive_q <= drive_n;
			power_q <= power_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			ctrl_s2  <= value_n;
			dir_s2   <= dir_n;
			af_s2    <= af_n;
			power_s2 <= power_n;
			mode_s2  <= mode_n;
			drive_s2 <= drive_n;
		end
	end

	assign out_valid        = valid_s2;
	assign ctrl_readback    = ctrl_s2;
	assign dir_readback     = dir_s2;
	assign af_readback      = af_s2;
	assign power_out_enable = power_s2;
	assign pin_modes        = mode_s2;
	assign pin_drive        = drive_s2;

endmodule

>>> hw/rtl/gbaf_checker.sv
module gbaf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [gbaf_pkg::BANK_W-1:0]          ctrl_readback,
	input logic [gbaf_pkg::BANK_W-1:0]          dir_readback,
	input logic [gbaf_pkg::AF_W-1:0]            af_readback,
	input logic [2*gbaf_pkg::SHARED_MAX-1:0]    pin_modes
);
	import gbaf_pkg::*;

	// A stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ctrl_readback)
			&& $stable(dir_readback) && $stable(pin_modes))
		else $error("stalled result changed");

	// Input-only pins never outputs, power pin always an output
	a_dir_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_readback[POWER_BIT:0] == DIR_RESET[POWER_BIT:0])
		else $error("fixed direction bits wrong");

	// First shared pin under GPIO follows its direction bit
	a_gpio_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && af_readback[1:0] == AF_GPIO
			|-> pin_modes[1:0] == {1'b0, dir_readback[SHARED_BASE]})
		else $error("GPIO pin mode does not follow direction");

	// First shared pin under UART is in UART mode
	a_uart_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && af_readback[1:0] == AF_UART
			|-> pin_modes[1:0] == MODE_UART)
		else $error("UART pin not in UART mode");

endmodule

bind gpio_bank_with_alt_function gbaf_checker u_gbaf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.ctrl_readback (ctrl_readback),
	.dir_readback  (dir_readback),
	.af_readback   (af_readback),
	.pin_modes     (pin_modes)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import gbaf_pkg::*;

	localparam int GROUPS          = 2;
	localparam int PER_GROUP       = 3;
	localparam int SHARED_N        = (GROUPS * PER_GROUP > SHARED_MAX) ? SHARED_MAX
		: GROUPS * PER_GROUP;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_ITEMS    = 1350;
	localparam int CHUNK_ITEMS     = 150;
	localparam int STREAM_ITEMS    = 150;

	// command codes with no effect, and alt-function codes with no defined mode
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam logic [1:0]       AF_RSVD_2       = 2'd2;
	localparam logic [1:0]       AF_RSVD_3       = 2'd3;

	typedef struct packed {
		logic [BANK_W-1:0]       ctrl;
		logic [BANK_W-1:0]       dir;
		logic [AF_W-1:0]         af;
		logic                    pwr;
		logic [2*SHARED_MAX-1:0] modes;
		logic [SHARED_MAX-1:0]   drive;
	} readback_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     command;
	logic [AF_W-1:0]      write_data;
	logic                 voltage_ok;
	logic [LEVEL_W-1:0]   pin_levels;
	logic                 out_valid;
	logic                 out_ready;
	logic [BANK_W-1:0]    ctrl_readback;
	logic [BANK_W-1:0]    dir_readback;
	logic [AF_W-1:0]      af_readback;
	logic                 power_out_enable;
	logic [2*SHARED_MAX-1:0] pin_modes;
	logic [SHARED_MAX-1:0]   pin_drive;

	// predicted bank state
	logic [BANK_W-1:0] bank_value = '0;
	logic [BANK_W-1:0] bank_dir   = DIR_RESET;
	logic [AF_W-1:0]   bank_af    = '0;
	logic [BANK_W-1:0] pend_mask  = '0;
	logic [BANK_W-1:0] pend_value = '0;
	mode_t             pin_mode [SHARED_MAX] = '{default: MODE_INPUT};
	logic              pin_drv  [SHARED_MAX] = '{default: 1'b0};
	logic              power_on   = 1'b0;

	readback_t readback_q[$];
	int        mismatches    = 0;
	int        items_sent    = 0;
	int        idle_cycles   = 0;
	bit        src_idle_on   = 1'b1;
	bit        sink_stall_on = 1'b1;
	bit        hold_off_req  = 1'b0;

	gpio_bank_with_alt_function #(
		.GROUP_COUNT(GROUPS),
		.PINS_PER_GROUP(PER_GROUP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.write_data(write_data),
		.voltage_ok(voltage_ok),
		.pin_levels(pin_levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctrl_readback(ctrl_readback),
		.dir_readback(dir_readback),
		.af_readback(af_readback),
		.power_out_enable(power_out_enable),
		.pin_modes(pin_modes),
		.pin_drive(pin_drive)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// direction write: shared pins follow it only while their code is GPIO
	function automatic void bank_write_dir(input logic [BANK_W-1:0] data);
		logic [BANK_W-1:0] nd;
		int b;
		logic v;
		nd = (data & ~11'h00F) | POWER_MASK;
		for (int s = 0; s < SHARED_N; s++) begin
			b = SHARED_BASE + s;
			if (nd[b] != bank_dir[b]) begin
				if (bank_af[2*s +: 2] == AF_GPIO) begin
					if (nd[b]) begin
						v = bank_value[b];
						if (pend_mask[b]) begin
							v = pend_value[b];
							pend_mask[b] = 1'b0;
							bank_value[b] = pend_value[b];
						end
						pin_drv[s] = v;
						pin_mode[s] = MODE_OUTPUT;
					end else begin
						pin_mode[s] = MODE_INPUT;
					end
				end else begin
					bank_value[b] = 1'b0;
				end
			end
		end
		bank_dir = nd;
	endfunction

	// modes from the alt-function codes; undefined codes keep the mode
	function automatic void bank_apply_af();
		for (int s = 0; s < SHARED_N; s++) begin
			case (bank_af[2*s +: 2])
				AF_GPIO: begin
					pin_mode[s] = bank_dir[SHARED_BASE + s] ? MODE_OUTPUT : MODE_INPUT;
				end
				AF_UART: begin
					pin_mode[s] = MODE_UART;
				end
				default: ;
			endcase
		end
	endfunction

	// update the bank state for one command and queue the readback it produces
	function automatic void bank_execute(input logic [CMD_W-1:0] cmd,
			input logic [AF_W-1:0] data, input logic vok, input logic [LEVEL_W-1:0] lv);
		readback_t r;
		int b;
		case (cmd)
			CMD_WR_VALUE: begin
				pend_value = data[BANK_W-1:0];
				pend_mask = data[BANK_W-1:0] ^ bank_value;
				bank_value = data[BANK_W-1:0];
				for (int s = 0; s < SHARED_N; s++) begin
					b = SHARED_BASE + s;
					if (pend_mask[b])
						pin_drv[s] = bank_value[b];
				end
			end
			CMD_WR_DIR: begin
				bank_write_dir(data[BANK_W-1:0]);
			end
			CMD_WR_AF: begin
				bank_af = data;
				bank_apply_af();
			end
			CMD_TICK: begin
				power_on = vok & bank_value[POWER_BIT];
				bank_value[INPUT_ONLY-1:0] = '0;
				for (int s = 0; s < SHARED_N; s++) begin
					if (pin_mode[s] == MODE_INPUT)
						bank_value[SHARED_BASE + s] = lv[s];
				end
			end
			CMD_HOST_RST: begin
				bank_value &= POWER_MASK;
				bank_af = '0;
				bank_write_dir(POWER_MASK);
				bank_apply_af();
			end
			default: ;
		endcase
		r.ctrl = bank_value;
		r.dir = bank_dir;
		r.af = bank_af;
		r.pwr = power_on;
		r.modes = '0;
		r.drive = '0;
		for (int s = 0; s < SHARED_N; s++) begin
			r.modes[2*s +: 2] = pin_mode[s];
			r.drive[s] = pin_drv[s];
		end
		readback_q.push_back(r);
	endfunction

	// alt-function word, mostly GPIO and UART with some undefined codes
	function automatic logic [AF_W-1:0] random_af_word();
		logic [AF_W-1:0] w;
		int unsigned r;
		for (int s = 0; s < SHARED_MAX; s++) begin
			r = $urandom_range(0, 11);
			if (r < 6)
				w[2*s +: 2] = AF_GPIO;
			else if (r < 10)
				w[2*s +: 2] = AF_UART;
			else if (r == 10)
				w[2*s +: 2] = AF_RSVD_2;
			else
				w[2*s +: 2] = AF_RSVD_3;
		end
		return w;
	endfunction

	// random supply monitor bit and shared pin levels
	function automatic logic rand_vok();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [LEVEL_W-1:0] rand_levels();
		return LEVEL_W'($urandom_range(0, 63));
	endfunction

	// one command transfer; entered and left at a falling edge
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [AF_W-1:0] data,
			input logic vok, input logic [LEVEL_W-1:0] lv);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		write_data = data;
		voltage_ok = vok;
		pin_levels = lv;
		do @(posedge clk); while (in_ready !== 1'b1);
		bank_execute(cmd, data, vok, lv);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int unsigned pick;
		logic [AF_W-1:0] d;
		pick = $urandom_range(0, 99);
		d = AF_W'($urandom_range(0, 4095));
		if (pick < 22)
			send_cmd(CMD_WR_VALUE, d, rand_vok(), rand_levels());
		else if (pick < 42)
			send_cmd(CMD_WR_DIR, d, rand_vok(), rand_levels());
		else if (pick < 55)
			send_cmd(CMD_WR_AF, random_af_word(), rand_vok(), rand_levels());
		else if (pick < 82)
			send_cmd(CMD_TICK, d, rand_vok(), rand_levels());
		else if (pick < 86)
			send_cmd(CMD_HOST_RST, d, rand_vok(), rand_levels());
		else if (pick < 89)
			send_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), d,
				rand_vok(), rand_levels());
		else begin
			// pins to input, value parked as pending, then a random direction write that may turn pins back to output
			send_cmd(CMD_WR_AF, random_af_word(), rand_vok(), rand_levels());
			send_cmd(CMD_WR_DIR, d & ~12'h7E0, rand_vok(), rand_levels());
			send_cmd(CMD_WR_VALUE, AF_W'($urandom_range(0, 4095)), rand_vok(),
				rand_levels());
			send_cmd(CMD_WR_DIR, AF_W'($urandom_range(0, 4095)), rand_vok(),
				rand_levels());
		end
	endtask

	task automatic test_idle_readback();
		send_cmd(CMD_SPARE_FIRST, 12'hFFF, 1'b1, 6'h3F);
		send_cmd(CMD_SPARE_LAST, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_TICK, 12'h000, 1'b1, 6'h3F);
	endtask

	task automatic test_value_and_power();
		send_cmd(CMD_WR_VALUE, 12'hFFF, 1'b0, 6'h00);
		send_cmd(CMD_TICK, 12'hFFF, 1'b1, 6'h00);
		send_cmd(CMD_TICK, 12'h000, 1'b0, 6'h2A);
	endtask

	task automatic test_direction_pending();
		send_cmd(CMD_WR_DIR, 12'hFFF, 1'b0, 6'h00);
		send_cmd(CMD_WR_VALUE, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_WR_DIR, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_WR_VALUE, 12'h7E0, 1'b0, 6'h00);
		send_cmd(CMD_TICK, 12'h000, 1'b1, 6'h15);
		send_cmd(CMD_WR_DIR, 12'h7E0, 1'b0, 6'h00);
	endtask

	task automatic test_alt_function();
		send_cmd(CMD_WR_AF, {SHARED_MAX{AF_UART}}, 1'b0, 6'h00);
		send_cmd(CMD_WR_DIR, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_WR_AF, {SHARED_MAX{AF_RSVD_2}}, 1'b0, 6'h00);
		send_cmd(CMD_WR_AF, {SHARED_MAX{AF_RSVD_3}}, 1'b0, 6'h00);
		send_cmd(CMD_WR_DIR, 12'hFFF, 1'b0, 6'h00);
		send_cmd(CMD_WR_AF, {AF_UART, AF_GPIO, AF_RSVD_3,
			AF_GPIO, AF_RSVD_2, AF_UART}, 1'b0, 6'h00);
		send_cmd(CMD_WR_VALUE, 12'h555, 1'b0, 6'h00);
	endtask

	task automatic test_host_reset();
		send_cmd(CMD_HOST_RST, 12'hFFF, 1'b1, 6'h3F);
		send_cmd(CMD_TICK, 12'h000, 1'b1, 6'h3F);
		send_cmd(CMD_HOST_RST, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_WR_AF, 12'h000, 1'b0, 6'h00);
		send_cmd(CMD_SPARE_FIRST + 3'd1, 12'h000, 1'b0, 6'h00);
	endtask

	// random commands in chunks, each chunk with its own idling pattern
	task automatic test_random_commands();
		int stop_at;
		int chunk_end;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			src_idle_on = $urandom_range(0, 3) != 0;
			sink_stall_on = $urandom_range(0, 3) != 0;
			chunk_end = items_sent + CHUNK_ITEMS;
			while (items_sent < chunk_end && items_sent < stop_at)
				send_random_item();
		end
	endtask

	// sink holds off while commands keep coming, so the input stalls
	task automatic test_backpressure();
		src_idle_on = 1'b0;
		hold_off_req = 1'b1;
		repeat (40)
			send_random_item();
		src_idle_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		int stop_at;
		src_idle_on = 1'b0;
		sink_stall_on = 1'b0;
		stop_at = items_sent + STREAM_ITEMS;
		while (items_sent < stop_at)
			send_random_item();
	endtask

	// result sink: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int unsigned n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 19);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare each readback transfer with the oldest prediction
	always @(posedge clk) begin : readback_check
		readback_t got;
		readback_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {ctrl_readback, dir_readback, af_readback, power_out_enable,
				pin_modes, pin_drive};
			if (readback_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected readback: ctrl=%h dir=%h af=%h pwr=%b modes=%h drive=%h",
						got.ctrl, got.dir, got.af, got.pwr, got.modes, got.drive);
			end else begin
				want = readback_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("readback mismatch at %0t:", $realtime);
						$display("  exp ctrl=%h dir=%h af=%h pwr=%b modes=%h drive=%h",
							want.ctrl, want.dir, want.af, want.pwr, want.modes, want.drive);
						$display("  got ctrl=%h dir=%h af=%h pwr=%b modes=%h drive=%h",
							got.ctrl, got.dir, got.af, got.pwr, got.modes, got.drive);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_top failed");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WR_VALUE;
		write_data = '0;
		voltage_ok = 1'b0;
		pin_levels = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_idle_readback();
		test_value_and_power();
		test_direction_pending();
		test_alt_function();
		test_host_reset();
		test_random_commands();
		test_backpressure();
		test_steady_stream();

		// drain outstanding readbacks
		in_valid = 1'b0;
		while (readback_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
